// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mshe_pkg.sv
package mshe_pkg;

  localparam int CHAR_W   = 8;
  localparam int MOD_W    = 31;
  localparam int MODE_W   = 2;
  localparam int HASH_W   = 32;
  localparam int DIGIT_W  = 9;
  // Magnitude of sum * 62 + digit stays below 2**37.
  localparam int DIVIDEND_W = 37;
  localparam int PROD_W     = 39;

  localparam logic [MOD_W-1:0]  MODULUS_RESET = 31'd65407;
  localparam logic [MODE_W-1:0] MODE_LOWER    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALNUM    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOLD     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_ALNUM;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_MODE    = 1'b1;

  localparam int GROUP_LENGTH_DEF = 4;

  localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_D0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_D9 = 8'h39;
  localparam logic [CHAR_W-1:0] ALPHA_N = 8'd26;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_FOLD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

endpackage

// File: design/mshe_char_map.sv
module mshe_char_map (
  input  logic [mshe_pkg::CHAR_W-1:0]         char_code,
  input  logic                                lower_mode,
  output logic signed [mshe_pkg::DIGIT_W-1:0] digit,
  output logic                                bad
);

  logic [mshe_pkg::CHAR_W-1:0] ofs;

  always_comb begin
    ofs   = '0;
    bad   = 1'b0;
    digit = '0;
    if (lower_mode) begin
      // Plain offset from 'a'; bytes below 'a' give a negative digit.
      digit = $signed({1'b0, char_code}) - $signed({1'b0, mshe_pkg::CHAR_LA});
    end else if (char_code inside {[mshe_pkg::CHAR_LA:mshe_pkg::CHAR_LZ]}) begin
      ofs   = char_code - mshe_pkg::CHAR_LA;
      digit = $signed({1'b0, ofs});
    end else if (char_code inside {[mshe_pkg::CHAR_UA:mshe_pkg::CHAR_UZ]}) begin
      ofs   = char_code - mshe_pkg::CHAR_UA + mshe_pkg::ALPHA_N;
      digit = $signed({1'b0, ofs});
    end else if (char_code inside {[mshe_pkg::CHAR_D0:mshe_pkg::CHAR_D9]}) begin
      ofs   = char_code - mshe_pkg::CHAR_D0 + mshe_pkg::ALPHA_N + mshe_pkg::ALPHA_N;
      digit = $signed({1'b0, ofs});
    end else begin
      bad = 1'b1;
    end
  end

endmodule

// File: design/mshe_reducer.sv
module mshe_reducer #(
  parameter int DIVIDEND_W = mshe_pkg::DIVIDEND_W,
  parameter int DIVISOR_W  = mshe_pkg::MOD_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVISOR_W-1:0]  rem,
  output mshe_pkg::red_stat_t   stat
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_nxt;

  // One dividend bit enters the partial remainder per cycle while the unit is busy, MSB first.
  always_comb begin
    trial   = {rem_r, dvd_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, div_r};
    rem_nxt = (trial >= {1'b0, div_r}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: design/modular_string_hash_engine_top.sv
// Channel  Handshake            Payload
// in       in_valid/in_ready    in_char_code[7:0], in_last_char
// out      out_valid/out_ready  out_hash_value[31:0] signed, out_bad_char
// cfg      cfg_we               cfg_index (0 modulus, 1 hash_mode), cfg_wdata[30:0]
//
// The radix-2 remainder unit walks the 37-bit dividend one bit per cycle. A
// character that closes a group or the string in mode 2 runs the unit a
// second time for the group sum.
// Reset is synchronous and active low; it restores both registers and clears
// the hash state. A result beat waits in the output register while the next
// character is taken; only a string's last character stalls while that beat is held.
module modular_string_hash_engine_top #(
  parameter int GROUP_LENGTH = mshe_pkg::GROUP_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mshe_pkg::CHAR_W-1:0]         in_char_code,
  input  logic                                in_last_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mshe_pkg::HASH_W-1:0]  out_hash_value,
  output logic                                out_bad_char,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [mshe_pkg::MOD_W-1:0]          cfg_wdata
);

  localparam int GP_W  = (GROUP_LENGTH > 1) ? $clog2(GROUP_LENGTH) : 1;
  localparam int MW    = mshe_pkg::MOD_W;
  localparam int HW    = mshe_pkg::HASH_W;
  localparam int PW    = mshe_pkg::PROD_W;
  localparam int DW    = mshe_pkg::DIVIDEND_W;

  mshe_pkg::state_t state_r, state_nxt;

  logic [MW-1:0]                modulus_r;
  logic [mshe_pkg::MODE_W-1:0]  mode_r;
  logic signed [HW-1:0]         rs_r;
  logic [MW-1:0]                ft_r;
  logic [GP_W-1:0]              gp_r;
  logic                         err_r;
  logic                         neg_r;
  logic                         last_r;

  logic                         out_valid_r;
  logic signed [HW-1:0]         out_hash_r;
  logic                         out_bad_r;

  logic [MW-1:0]                m_eff;
  logic                         lower_mode;
  logic                         fold_mode;
  logic signed [mshe_pkg::DIGIT_W-1:0] digit;
  logic                         bad;
  logic signed [PW-1:0]         rs_ext;
  logic signed [PW-1:0]         prod;
  logic [PW-1:0]                mag;
  logic [GP_W:0]                gp_inc;
  logic                         group_end;
  logic                         fold_now;
  logic [MW-1:0]                red_rem;
  mshe_pkg::red_stat_t          red_stat;
  logic signed [HW-1:0]         rs_new;
  logic [MW:0]                  fold_sum;

  logic                         accept;
  logic                         red_start;
  logic [DW-1:0]                red_dvd;
  logic                         out_free;
  logic                         load_out;

  assign m_eff      = (modulus_r == '0) ? MW'(1) : modulus_r;
  assign lower_mode = (mode_r == mshe_pkg::MODE_LOWER);
  assign fold_mode  = (mode_r == mshe_pkg::MODE_FOLD);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;

  mshe_char_map u_map (
    .char_code  (in_char_code),
    .lower_mode (lower_mode),
    .digit      (digit),
    .bad        (bad)
  );

  // sum * 26 or sum * 62 as shifted adds, plus the character digit.
  always_comb begin
    rs_ext = PW'(rs_r);
    if (lower_mode) begin
      prod = (rs_ext <<< 4) + (rs_ext <<< 3) + (rs_ext <<< 1) + PW'(digit);
    end else begin
      prod = (rs_ext <<< 6) - (rs_ext <<< 1) + PW'(digit);
    end
    mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
  end

  assign gp_inc    = {1'b0, gp_r} + 1'b1;
  assign group_end = (gp_inc >= (GP_W+1)'(GROUP_LENGTH));
  assign fold_now  = fold_mode && (group_end || last_r);

  mshe_reducer #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (MW)
  ) u_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (red_start),
    .dividend (red_dvd),
    .divisor  (m_eff),
    .rem      (red_rem),
    .stat     (red_stat)
  );

  // Truncating remainder in mode 0; the other modes fold negatives into 0..m-1.
  always_comb begin
    if (lower_mode) begin
      rs_new = neg_r ? -$signed({1'b0, red_rem}) : $signed({1'b0, red_rem});
    end else if (neg_r && (red_rem != '0)) begin
      rs_new = $signed({1'b0, m_eff - red_rem});
    end else begin
      rs_new = $signed({1'b0, red_rem});
    end
    fold_sum = {1'b0, ft_r} + {1'b0, rs_new[MW-1:0]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mshe_pkg::ST_IDLE: begin
        if (accept) state_nxt = mshe_pkg::ST_RED;
      end
      mshe_pkg::ST_RED: begin
        if (red_stat.done) begin
          state_nxt = fold_now ? mshe_pkg::ST_FOLD : mshe_pkg::ST_FIN;
        end
      end
      mshe_pkg::ST_FOLD: begin
        if (red_stat.done) state_nxt = mshe_pkg::ST_FIN;
      end
      mshe_pkg::ST_FIN: begin
        if (!last_r || out_free) state_nxt = mshe_pkg::ST_IDLE;
      end
      default: state_nxt = mshe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    red_start = 1'b0;
    red_dvd   = mag[DW-1:0];
    load_out  = 1'b0;
    case (state_r)
      mshe_pkg::ST_IDLE: begin
        in_ready  = !red_stat.busy;
        red_start = accept;
      end
      mshe_pkg::ST_RED: begin
        red_dvd   = DW'(fold_sum);
        red_start = red_stat.done && fold_now;
      end
      mshe_pkg::ST_FIN: begin
        load_out = last_r && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mshe_pkg::ST_IDLE;
      modulus_r <= mshe_pkg::MODULUS_RESET;
      mode_r    <= mshe_pkg::MODE_RESET;
      rs_r      <= '0;
      ft_r      <= '0;
      gp_r      <= '0;
      err_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == mshe_pkg::REG_MODULUS) begin
          modulus_r <= cfg_wdata;
        end else begin
          mode_r <= cfg_wdata[mshe_pkg::MODE_W-1:0];
        end
      end
      if (accept && bad && !lower_mode) err_r <= 1'b1;
      if (state_r == mshe_pkg::ST_RED && red_stat.done) begin
        if (fold_now) begin
          rs_r <= '0;
          gp_r <= '0;
        end else begin
          rs_r <= rs_new;
          if (fold_mode) gp_r <= gp_inc[GP_W-1:0];
        end
      end
      if (state_r == mshe_pkg::ST_FOLD && red_stat.done) ft_r <= red_rem;
      if (load_out) begin
        rs_r  <= '0;
        ft_r  <= '0;
        gp_r  <= '0;
        err_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r  <= prod[PW-1];
      last_r <= in_last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hash_r <= fold_mode ? $signed({1'b0, ft_r}) : rs_r;
      out_bad_r  <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_bad_char   = out_bad_r;

endmodule

// File: design/mshe_checker.sv
`include "assert_macros.svh"

module mshe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mshe_pkg::HASH_W-1:0] out_hash_value,
  input logic                               out_bad_char
);

  // A held result beat keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_hash_value) && $stable(out_bad_char), "result beat changed while stalled")

  // Every character occupies the serial reducer before the next one is taken.
  `ASSERT_IMPL(a_busy_after_accept, clk, rst_n, in_valid && in_ready, ##20 !in_ready, "input taken again too early")

  // A result only appears after the engine was busy with a character.
  `ASSERT_IMPL(a_result_after_work, clk, rst_n, $rose(out_valid), $past(!in_ready), "result beat without preceding work")

  // A reduced hash never reaches the most negative 32-bit value.
  `ASSERT_IMPL(a_hash_range, clk, rst_n, out_valid, out_hash_value != 32'sh80000000, "hash out of range")

endmodule

bind modular_string_hash_engine_top mshe_checker u_mshe_checker (.*);
